FILE: sv/pnt_pkg.sv
package pnt_pkg;

  // table of note frequencies in tenths of a hertz
  localparam int TABLE_ENTRIES = 130;
  localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
  localparam int IDX_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int TBL_W         = 18;

  localparam int COUNT_WIDTH   = 8;

  // divider geometry: numerator times ten over a 16 bit denominator
  localparam int NUM_W         = 24;
  localparam int DEN_W         = 16;
  localparam int QUO_W         = 28;
  localparam int FREQ_W        = 32;
  localparam int DIV_CNT_W     = $clog2(QUO_W);

  localparam int PADDR_W       = 5;
  localparam int PDATA_W       = 32;

  localparam logic [7:0] NO_NOTE   = 8'd255;

  localparam logic [6:0] RATIO_UP   = 7'd80;
  localparam logic [6:0] RATIO_DOWN = 7'd20;
  localparam logic [6:0] RATIO_MID  = 7'd50;
  localparam int         PERCENT    = 100;

  typedef enum logic [2:0] {
    REG_ACTIVE_LEVEL,
    REG_BUTTON_ENABLE,
    REG_MAX_NOTE,
    REG_MIN_NOTE,
    REG_SCALE_MASK,
    REG_EXTEND_FRAMES,
    REG_SUPPRESS_FRAMES,
    REG_KEEP_FRAMES
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SETUP,
    ST_FETCH,
    ST_TEST,
    ST_FINISH
  } state_t;

  localparam logic [TBL_W-1:0] NOTE_FREQ [0:TABLE_ENTRIES-1] = '{
    18'd77,
    18'd82, 18'd87, 18'd92, 18'd97, 18'd103, 18'd109, 18'd116, 18'd122,
    18'd130, 18'd138, 18'd146, 18'd154,
    18'd164, 18'd173, 18'd184, 18'd194, 18'd206, 18'd218, 18'd231, 18'd245,
    18'd260, 18'd275, 18'd291, 18'd309,
    18'd327, 18'd346, 18'd367, 18'd389, 18'd412, 18'd437, 18'd462, 18'd490,
    18'd519, 18'd550, 18'd583, 18'd617,
    18'd654, 18'd693, 18'd734, 18'd778, 18'd824, 18'd873, 18'd925, 18'd980,
    18'd1038, 18'd1100, 18'd1165, 18'd1235,
    18'd1308, 18'd1386, 18'd1468, 18'd1556, 18'd1648, 18'd1746, 18'd1850,
    18'd1960, 18'd2077, 18'd2200, 18'd2331, 18'd2469,
    18'd2616, 18'd2772, 18'd2937, 18'd3111, 18'd3296, 18'd3492, 18'd3700,
    18'd3920, 18'd4153, 18'd4400, 18'd4662, 18'd4939,
    18'd5233, 18'd5544, 18'd5873, 18'd6223, 18'd6593, 18'd6985, 18'd7400,
    18'd7840, 18'd8306, 18'd8800, 18'd9323, 18'd9878,
    18'd10465, 18'd11087, 18'd11747, 18'd12445, 18'd13185, 18'd13969,
    18'd14800, 18'd15680, 18'd16612, 18'd17600, 18'd18647, 18'd19755,
    18'd20930, 18'd22175, 18'd23493, 18'd24890, 18'd26370, 18'd27938,
    18'd29600, 18'd31360, 18'd33224, 18'd35200, 18'd37293, 18'd39511,
    18'd41860, 18'd44349, 18'd46986, 18'd49780, 18'd52740, 18'd55877,
    18'd59199, 18'd62719, 18'd66449, 18'd70400, 18'd74586, 18'd79021,
    18'd83720, 18'd88698, 18'd93973, 18'd99561, 18'd105481, 18'd111753,
    18'd118398, 18'd125439,
    18'd132898
  };

  // entries past the end of the table read as zero
  function automatic logic [TBL_W-1:0] note_freq(input logic [TBL_AW-1:0] idx);
    logic [TBL_W-1:0] val;
    val = '0;
    if (int'(idx) < TABLE_ENTRIES) begin
      val = NOTE_FREQ[idx];
    end
    return val;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH-1:0] val;
    val = (c != '1) ? c + 1'b1 : c;
    return val;
  endfunction

endpackage

FILE: sv/pitch_to_note_tracker.sv
// pitch to note tracker: one request per audio frame carries a pitch as
// numerator over denominator, a volume and the perform button level; one
// result per frame reports a note-off and/or a note-on event. The pitch is
// turned into tenths of a hertz by a bit-serial divider, then a single
// threshold unit walks the note frequency table, fetching and testing each
// entry allowed by the scale mask and skipping each masked entry. Hysteresis
// uses 80% of the gap above the held note, 20% at or below it and 50% with
// no note held. The block takes one request at a time, but accepts the next
// one while the previous result still waits on the output. Frame counters
// extend a held note over short pitch dropouts and quiet spells and mute the
// first frames after an onset; they saturate.
module pitch_to_note_tracker (
  input  logic                        clk,
  input  logic                        rst,
  // request stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [23:0] pitch_numerator, [39:24] pitch_denominator, [55:40] volume,
  // [56] button_pressed, [63:57] zero
  input  logic [63:0]                 s_tdata,
  // result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [0] off_valid, [7:1] off_note, [8] on_valid, [15:9] on_note
  output logic [15:0]                 m_tdata,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pnt_pkg::PADDR_W-1:0] paddr,
  input  logic [pnt_pkg::PDATA_W-1:0] pwdata,
  output logic [pnt_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] active_level;
  logic        button_enable;
  logic [6:0]  max_note;
  logic [6:0]  min_note;
  logic [11:0] scale_mask;
  logic [7:0]  extend_frames;
  logic [7:0]  suppress_frames;
  logic [7:0]  keep_frames;

  logic             cfg_wr;
  pnt_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = pnt_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_level    <= 16'd300;
      button_enable   <= 1'b0;
      max_note        <= 7'd127;
      min_note        <= 7'd0;
      scale_mask      <= 12'hfff;
      extend_frames   <= 8'd5;
      suppress_frames <= 8'd3;
      keep_frames     <= 8'd3;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pnt_pkg::REG_ACTIVE_LEVEL:    active_level    <= pwdata[15:0];
        pnt_pkg::REG_BUTTON_ENABLE:   button_enable   <= pwdata[0];
        pnt_pkg::REG_MAX_NOTE:        max_note        <= pwdata[6:0];
        pnt_pkg::REG_MIN_NOTE:        min_note        <= pwdata[6:0];
        pnt_pkg::REG_SCALE_MASK:      scale_mask      <= pwdata[11:0];
        pnt_pkg::REG_EXTEND_FRAMES:   extend_frames   <= pwdata[7:0];
        pnt_pkg::REG_SUPPRESS_FRAMES: suppress_frames <= pwdata[7:0];
        pnt_pkg::REG_KEEP_FRAMES:     keep_frames     <= pwdata[7:0];
      endcase
    end
  end

  // register readback, zero extended
  always_comb begin
    unique case (cfg_idx)
      pnt_pkg::REG_ACTIVE_LEVEL:    prdata = 32'(active_level);
      pnt_pkg::REG_BUTTON_ENABLE:   prdata = 32'(button_enable);
      pnt_pkg::REG_MAX_NOTE:        prdata = 32'(max_note);
      pnt_pkg::REG_MIN_NOTE:        prdata = 32'(min_note);
      pnt_pkg::REG_SCALE_MASK:      prdata = 32'(scale_mask);
      pnt_pkg::REG_EXTEND_FRAMES:   prdata = 32'(extend_frames);
      pnt_pkg::REG_SUPPRESS_FRAMES: prdata = 32'(suppress_frames);
      pnt_pkg::REG_KEEP_FRAMES:     prdata = 32'(keep_frames);
    endcase
  end

  // ---------------------------------------------------------------------
  // request capture and divider
  // ---------------------------------------------------------------------
  pnt_pkg::state_t state, state_next;

  logic                          in_acc;
  logic [pnt_pkg::NUM_W-1:0]     in_num;
  logic [pnt_pkg::DEN_W-1:0]     in_den;
  logic [pnt_pkg::QUO_W-1:0]     num_x10;

  logic                          den_zero;
  logic [15:0]                   volume;
  logic                          button;

  logic                          div_done;
  logic [pnt_pkg::QUO_W-1:0]     div_quo;

  assign s_tready = (state == pnt_pkg::ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign in_num   = s_tdata[23:0];
  assign in_den   = s_tdata[39:24];
  // times ten as two shifted copies
  assign num_x10  = (pnt_pkg::QUO_W'(in_num) << 3) + (pnt_pkg::QUO_W'(in_num) << 1);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      den_zero <= (in_den == '0);
      volume   <= s_tdata[55:40];
      button   <= s_tdata[56];
    end
  end

  pnt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (in_acc),
    .dividend (num_x10),
    .divisor  (in_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------------------------------------------------------------
  // table walk through the shared threshold unit
  // ---------------------------------------------------------------------
  logic [pnt_pkg::FREQ_W-1:0]  freq;
  logic [6:0]                  ratio;
  logic [pnt_pkg::TBL_AW-1:0]  lo;
  logic [pnt_pkg::IDX_W-1:0]   idx;
  logic [3:0]                  cls;
  logic                        below;
  logic                        big;
  logic [23:0]                 lhs;
  logic [24:0]                 rhs;

  logic [7:0]                  held_note;
  logic [pnt_pkg::TBL_W-1:0]   cur;

  logic [pnt_pkg::TBL_W-1:0]   tbl_a;
  logic [pnt_pkg::TBL_W-1:0]   tbl_b;
  logic [pnt_pkg::TBL_W-1:0]   gap;
  logic [pnt_pkg::FREQ_W-1:0]  xdiff;
  logic [16:0]                 xp1;
  logic                        below_c;
  logic                        big_c;
  logic [23:0]                 lhs_c;
  logic [24:0]                 rhs_c;
  logic                        walk_end;
  logic                        mask_on;
  logic                        brk;
  logic [3:0]                  cls_inc;

  // held note frequency, zero when nothing is held
  always_comb begin
    cur = '0;
    if (held_note != pnt_pkg::NO_NOTE) begin
      cur = pnt_pkg::note_freq(pnt_pkg::TBL_AW'(held_note + 8'd1));
    end
  end

  // freq below a + floor(gap * ratio / 100) is the same as
  // 100 * (freq - a + 1) <= gap * ratio once freq reaches a; distances of
  // 65535 or more never fall below any threshold
  always_comb begin
    tbl_a    = pnt_pkg::note_freq(lo);
    tbl_b    = pnt_pkg::note_freq(idx[pnt_pkg::TBL_AW-1:0]);
    gap      = tbl_b - tbl_a;
    xdiff    = freq - pnt_pkg::FREQ_W'(tbl_a);
    below_c  = freq < pnt_pkg::FREQ_W'(tbl_a);
    big_c    = xdiff >= 32'd65535;
    xp1      = {1'b0, xdiff[15:0]} + 17'd1;
    lhs_c    = 24'(xp1) * 24'(pnt_pkg::PERCENT);
    rhs_c    = 25'(gap) * 25'(ratio);
    walk_end = int'(idx) >= pnt_pkg::TABLE_ENTRIES;
    mask_on  = scale_mask[cls];
    brk      = below || (!big && ({1'b0, lhs} <= rhs));
    cls_inc  = (cls == 4'd11) ? 4'd0 : cls + 4'd1;
  end

  // ---------------------------------------------------------------------
  // frame decision: note window, frame counters, button gate
  // ---------------------------------------------------------------------
  logic [pnt_pkg::COUNT_WIDTH-1:0] lost_count, lost_next;
  logic [pnt_pkg::COUNT_WIDTH-1:0] loud_count, loud_next;
  logic [pnt_pkg::COUNT_WIDTH-1:0] quiet_count, quiet_next;

  logic [7:0]                      found;
  logic [7:0]                      note;
  logic [7:0]                      nt;
  logic                            loud;
  logic [pnt_pkg::IDX_W:0]         lo_p2;
  logic                            out_free;
  logic                            finish;
  logic [15:0]                     result;

  always_comb begin
    nt    = 8'(lo) - 8'd1;
    lo_p2 = (pnt_pkg::IDX_W + 1)'(lo) + 2'd2;
    found = pnt_pkg::NO_NOTE;
    // no note if the lookup stopped below the first note or past the last one
    if (lo != '0 && int'(lo_p2) <= pnt_pkg::TABLE_ENTRIES) begin
      if (nt >= {1'b0, min_note} && nt <= {1'b0, max_note}) begin
        found = nt;
      end
    end

    loud       = volume >= active_level;
    note       = found;
    lost_next  = lost_count;
    loud_next  = loud_count;
    quiet_next = quiet_count;

    // pitch lost while loud: extend the held note for a few frames
    if (found == pnt_pkg::NO_NOTE && loud) begin
      if (16'(lost_count) < 16'(extend_frames)) begin
        lost_next = pnt_pkg::sat_inc(lost_count);
        note      = held_note;
      end
    end else begin
      lost_next = '0;
    end

    if (!loud) begin
      // quiet spell: keep the note for a few frames
      loud_next = '0;
      if (16'(quiet_count) < 16'(keep_frames)) begin
        note = held_note;
      end
      quiet_next = pnt_pkg::sat_inc(quiet_count);
    end else begin
      // fresh onset: mute the first frames
      if (16'(loud_count) < 16'(suppress_frames)) begin
        note = pnt_pkg::NO_NOTE;
      end
      loud_next  = pnt_pkg::sat_inc(loud_count);
      quiet_next = '0;
    end

    if (button_enable && !button) begin
      note = pnt_pkg::NO_NOTE;
    end

    result = '0;
    if (note != held_note) begin
      if (held_note != pnt_pkg::NO_NOTE) begin
        result[0]   = 1'b1;
        result[7:1] = held_note[6:0];
      end
      if (note != pnt_pkg::NO_NOTE) begin
        result[8]    = 1'b1;
        result[15:9] = note[6:0];
      end
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign finish   = (state == pnt_pkg::ST_FINISH) && out_free;

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pnt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pnt_pkg::ST_IDLE: begin
        if (in_acc) state_next = pnt_pkg::ST_DIVIDE;
      end
      pnt_pkg::ST_DIVIDE: begin
        if (div_done) state_next = pnt_pkg::ST_SETUP;
      end
      pnt_pkg::ST_SETUP: begin
        state_next = pnt_pkg::ST_FETCH;
      end
      pnt_pkg::ST_FETCH: begin
        priority if (walk_end) begin
          state_next = pnt_pkg::ST_FINISH;
        end else if (mask_on) begin
          state_next = pnt_pkg::ST_TEST;
        end
      end
      pnt_pkg::ST_TEST: begin
        state_next = brk ? pnt_pkg::ST_FINISH : pnt_pkg::ST_FETCH;
      end
      pnt_pkg::ST_FINISH: begin
        if (out_free) state_next = pnt_pkg::ST_IDLE;
      end
      default: state_next = pnt_pkg::ST_IDLE;
    endcase
  end

  // walk datapath
  always_ff @(posedge clk) begin
    unique case (state)
      pnt_pkg::ST_DIVIDE: begin
        if (div_done) begin
          freq <= den_zero ? '1 : pnt_pkg::FREQ_W'(div_quo);
        end
      end
      pnt_pkg::ST_SETUP: begin
        lo  <= '0;
        idx <= pnt_pkg::IDX_W'(1);
        cls <= 4'd0;
        priority if (cur == '0) begin
          ratio <= pnt_pkg::RATIO_MID;
        end else if (freq > pnt_pkg::FREQ_W'(cur)) begin
          ratio <= pnt_pkg::RATIO_UP;
        end else begin
          ratio <= pnt_pkg::RATIO_DOWN;
        end
      end
      pnt_pkg::ST_FETCH: begin
        if (!walk_end) begin
          if (mask_on) begin
            below <= below_c;
            big   <= big_c;
            lhs   <= lhs_c;
            rhs   <= rhs_c;
          end else begin
            idx <= idx + 1'b1;
            cls <= cls_inc;
          end
        end
      end
      pnt_pkg::ST_TEST: begin
        if (!brk) begin
          lo  <= idx[pnt_pkg::TBL_AW-1:0];
          idx <= idx + 1'b1;
          cls <= cls_inc;
        end
      end
      default: ;
    endcase
  end

  // tracker state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_note   <= pnt_pkg::NO_NOTE;
      lost_count  <= '0;
      loud_count  <= '0;
      quiet_count <= '0;
      m_tvalid    <= 1'b0;
    end else if (finish) begin
      if (note != held_note) begin
        held_note <= note;
      end
      lost_count  <= lost_next;
      loud_count  <= loud_next;
      quiet_count <= quiet_next;
      m_tvalid    <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= result;
    end
  end

`ifndef SYNTHESIS
  // the held note is always a real note number or the no-note mark
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held_note == pnt_pkg::NO_NOTE || held_note[7] == 1'b0)
    else $error("held note out of range");

  // the lower bracket always trails the entry under test
  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    state == pnt_pkg::ST_TEST |-> pnt_pkg::IDX_W'(lo) < idx)
    else $error("table walk bracket out of order");

  // a fresh result only ever follows the decision step
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == pnt_pkg::ST_FINISH)
    else $error("result raised outside the decision step");

  // a note-on never repeats the note already held
  a_on_differs: assert property (@(posedge clk) disable iff (rst)
    finish && result[8] |-> ({1'b0, result[15:9]} != held_note))
    else $error("note-on for the held note");
`endif

endmodule

FILE: sv/pnt_div.sv
// restoring divider, one quotient bit per cycle
module pnt_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pnt_pkg::QUO_W-1:0] dividend,
  input  logic [pnt_pkg::DEN_W-1:0] divisor,
  output logic                      done,
  output logic [pnt_pkg::QUO_W-1:0] quotient
);

  logic                          busy;
  logic [pnt_pkg::DIV_CNT_W-1:0] cnt;
  logic [pnt_pkg::DEN_W-1:0]     rem;
  logic [pnt_pkg::DEN_W-1:0]     dsr;
  logic [pnt_pkg::QUO_W-1:0]     quo;

  logic [pnt_pkg::DEN_W:0]       shifted;
  logic [pnt_pkg::DEN_W:0]       diff;
  logic                          ge;

  always_comb begin
    shifted = {rem, quo[pnt_pkg::QUO_W-1]};
    diff    = shifted - {1'b0, dsr};
    ge      = shifted >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= pnt_pkg::DIV_CNT_W'(pnt_pkg::QUO_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[pnt_pkg::DEN_W-1:0] : shifted[pnt_pkg::DEN_W-1:0];
      quo <= {quo[pnt_pkg::QUO_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule
